// ===== sv/sdspi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdspi_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
   localparam int FIFO_DEPTH = 8;
   localparam int MAX_RESULTS = 4;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_REPLY = 3'd3;
   localparam logic [2:0] OP_WDATA = 3'd4;

   localparam logic [2:0] KIND_SEND  = 3'd0;
   localparam logic [2:0] KIND_CHIP  = 3'd1;
   localparam logic [2:0] KIND_CLOCK = 3'd2;
   localparam logic [2:0] KIND_RDATA = 3'd3;
   localparam logic [2:0] KIND_NEED  = 3'd4;
   localparam logic [2:0] KIND_DONE  = 3'd5;

   localparam logic [3:0] ST_OK          = 4'd0;
   localparam logic [3:0] ST_NO_IDLE     = 4'd1;
   localparam logic [3:0] ST_ACMD41_ERR  = 4'd2;
   localparam logic [3:0] ST_ACMD41_TMO  = 4'd3;
   localparam logic [3:0] ST_BLKLEN_FAIL = 4'd4;
   localparam logic [3:0] ST_READ_REJ    = 4'd5;
   localparam logic [3:0] ST_TOKEN_TMO   = 4'd6;
   localparam logic [3:0] ST_WRITE_REJ   = 4'd7;
   localparam logic [3:0] ST_DATA_REJ    = 4'd8;
   localparam logic [3:0] ST_BUSY_TMO    = 4'd9;

   localparam logic [2:0] REG_POLL  = 3'd0;
   localparam logic [2:0] REG_RETRY = 3'd1;
   localparam logic [2:0] REG_TOKEN = 3'd2;
   localparam logic [2:0] REG_BUSY  = 3'd3;
   localparam logic [2:0] REG_WAKE  = 3'd4;

   localparam logic [2:0] C_CMD0  = 3'd0;
   localparam logic [2:0] C_CMD8  = 3'd1;
   localparam logic [2:0] C_CMD55 = 3'd2;
   localparam logic [2:0] C_CMD41 = 3'd3;
   localparam logic [2:0] C_CMD58 = 3'd4;
   localparam logic [2:0] C_CMD16 = 3'd5;
   localparam logic [2:0] C_CMD17 = 3'd6;
   localparam logic [2:0] C_CMD24 = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] lba;
      logic [7:0]  byte_in;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] tx_byte;
      logic       cs_active;
      logic       fast_clock;
      logic [7:0] data_byte;
      logic [3:0] status;
      logic       high_capacity;
      logic       is_last;
   } rsp_type;

   function automatic rsp_type f_send(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.kind = KIND_SEND;
      r.tx_byte = b;
      return r;
   endfunction

   function automatic rsp_type f_chip(input logic lvl);
      rsp_type r;
      r = '0;
      r.kind = KIND_CHIP;
      r.cs_active = lvl;
      return r;
   endfunction

   function automatic rsp_type f_clock(input logic fast);
      rsp_type r;
      r = '0;
      r.kind = KIND_CLOCK;
      r.fast_clock = fast;
      return r;
   endfunction

   function automatic rsp_type f_rdata(input logic [7:0] d);
      rsp_type r;
      r = '0;
      r.kind = KIND_RDATA;
      r.data_byte = d;
      return r;
   endfunction

   function automatic rsp_type f_need();
      rsp_type r;
      r = '0;
      r.kind = KIND_NEED;
      return r;
   endfunction

   function automatic rsp_type f_done(input logic [3:0] st, input logic hc);
      rsp_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.status = st;
      r.high_capacity = hc;
      return r;
   endfunction

   function automatic logic [7:0] cmd_num(input logic [2:0] idx);
      logic [7:0] v;
      unique case (idx)
         C_CMD0:  v = 8'd0;
         C_CMD8:  v = 8'd8;
         C_CMD55: v = 8'd55;
         C_CMD41: v = 8'd41;
         C_CMD58: v = 8'd58;
         C_CMD16: v = 8'd16;
         C_CMD17: v = 8'd17;
         default: v = 8'd24;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] cmd_crc(input logic [2:0] idx);
      logic [7:0] v;
      unique case (idx)
         C_CMD0:  v = 8'h95;
         C_CMD8:  v = 8'h87;
         C_CMD55: v = 8'h65;
         C_CMD41: v = 8'h77;
         C_CMD58: v = 8'hFD;
         C_CMD16: v = 8'h15;
         default: v = 8'hFF;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] cmd_arg(input logic [2:0] idx, input logic v2,
                                           input logic [31:0] addr);
      logic [31:0] a;
      unique case (idx)
         C_CMD8:  a = 32'h0000_01AA;
         C_CMD41: a = v2 ? 32'h4000_0000 : 32'h0;
         C_CMD16: a = 32'(BLOCK_BYTES);
         C_CMD17: a = addr;
         C_CMD24: a = addr;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [2:0] k,
                                             input logic v2, input logic [31:0] addr);
      logic [31:0] a;
      logic [7:0]  v;
      a = cmd_arg(idx, v2, addr);
      priority case (k)
         3'd0: v = 8'hFF;
         3'd1: v = 8'h40 | cmd_num(idx);
         3'd2: v = a[31:24];
         3'd3: v = a[23:16];
         3'd4: v = a[15:8];
         3'd5: v = a[7:0];
         default: v = cmd_crc(idx);
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/sd_spi_mode_host_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   sdspi_pkg::req_type (op, lba, byte_in)
// rsp      out        rsp_valid/rsp_stall   sdspi_pkg::rsp_type
// csr      in         csr_valid/csr_ready   csr_index, csr_data (17 bits)
//
// One request beat is taken per cycle while req_stall is low; its zero to three result beats
// are formed in the same cycle and written into an eight-entry result queue.
// The queue drains one beat per cycle while rsp_stall is low.
// req_stall rises while fewer than four queue entries are free.
// Reset is synchronous: idle phase, empty queue, limits at their defaults.
module sd_spi_mode_host_sequencer_core (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  sdspi_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sdspi_pkg::rsp_type  rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [2:0]          csr_index,
   input  wire  [16:0]         csr_data
);

   localparam logic [5:0] PH_IDLE  = 6'd0;
   localparam logic [5:0] PH_WAKE  = 6'd1;
   localparam logic [5:0] PH_FRAME = 6'd2;
   localparam logic [5:0] PH_POLL  = 6'd10;
   localparam logic [5:0] PH_T0    = 6'd18;
   localparam logic [5:0] PH_R7    = 6'd19;
   localparam logic [5:0] PH_T8    = 6'd20;
   localparam logic [5:0] PH_T41   = 6'd21;
   localparam logic [5:0] PH_OCR   = 6'd22;
   localparam logic [5:0] PH_T58   = 6'd23;
   localparam logic [5:0] PH_T16   = 6'd24;
   localparam logic [5:0] PH_RTOK  = 6'd25;
   localparam logic [5:0] PH_RDAT  = 6'd26;
   localparam logic [5:0] PH_RCRC  = 6'd27;
   localparam logic [5:0] PH_WGAP  = 6'd28;
   localparam logic [5:0] PH_WTOK  = 6'd29;
   localparam logic [5:0] PH_WNEED = 6'd30;
   localparam logic [5:0] PH_WDAT  = 6'd31;
   localparam logic [5:0] PH_WCRC  = 6'd32;
   localparam logic [5:0] PH_WRESP = 6'd33;
   localparam logic [5:0] PH_WBUSY = 6'd34;
   localparam logic [5:0] PH_WTAIL = 6'd35;

   localparam int PTR_W = $clog2(sdspi_pkg::FIFO_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [7:0]  poll_lim_ff;
   logic [15:0] retry_lim_ff;
   logic [16:0] token_lim_ff;
   logic [16:0] busy_lim_ff;
   logic [7:0]  wake_lim_ff;

   logic [5:0]  phase_ff, phase_in;
   logic [16:0] bcount_ff, bcount_in;
   logic [15:0] retry_ff, retry_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  r1_ff, r1_in;
   logic        v2_ff, v2_in;
   logic        hc_ff, hc_in;
   logic [1:0]  flags_ff, flags_in;

   sdspi_pkg::rsp_type queue_ff [sdspi_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]   head_ff, tail_ff;
   logic [CNT_W-1:0]   count_ff;

   sdspi_pkg::rsp_type res [sdspi_pkg::MAX_RESULTS];
   logic [2:0]         nres;
   logic               req_accept;
   logic               rsp_pop;

   assign csr_ready  = 1'b1;
   assign req_stall  = count_ff > CNT_W'(sdspi_pkg::FIFO_DEPTH - sdspi_pkg::MAX_RESULTS);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = count_ff != '0;
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign rsp_data   = queue_ff[head_ff];

   always_comb begin
      logic [2:0] idx;
      logic [7:0] b;
      phase_in = phase_ff;
      bcount_in = bcount_ff;
      retry_in = retry_ff;
      addr_in = addr_ff;
      r1_in = r1_ff;
      v2_in = v2_ff;
      hc_in = hc_ff;
      flags_in = flags_ff;
      nres = 3'd0;
      for (int i = 0; i < sdspi_pkg::MAX_RESULTS; i++) begin
         res[i] = '0;
      end
      b = req_data.byte_in;
      idx = 3'((phase_ff >= PH_POLL) ? (phase_ff - PH_POLL) : (phase_ff - PH_FRAME));
      if (req_accept) begin
         priority case (req_data.op)
            sdspi_pkg::OP_INIT: begin
               if (phase_ff == PH_IDLE) begin
                  v2_in = 1'b0;
                  hc_in = 1'b0;
                  res[0] = sdspi_pkg::f_clock(1'b0);
                  res[1] = sdspi_pkg::f_chip(1'b0);
                  res[2] = sdspi_pkg::f_send(8'hFF);
                  nres = 3'd3;
                  bcount_in = 17'd1;
                  phase_in = PH_WAKE;
               end
            end
            sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  addr_in = hc_ff ? req_data.lba : (req_data.lba << sdspi_pkg::BLK_SHIFT);
                  res[0] = sdspi_pkg::f_chip(1'b1);
                  res[1] = sdspi_pkg::f_send(8'hFF);
                  nres = 3'd2;
                  bcount_in = '0;
                  phase_in = PH_FRAME + ((req_data.op == sdspi_pkg::OP_READ)
                             ? 6'(sdspi_pkg::C_CMD17) : 6'(sdspi_pkg::C_CMD24));
               end
            end
            sdspi_pkg::OP_WDATA: begin
               if (phase_ff == PH_WNEED) begin
                  res[0] = sdspi_pkg::f_send(b);
                  nres = 3'd1;
                  phase_in = PH_WDAT;
               end
            end
            sdspi_pkg::OP_REPLY: begin
               if (phase_ff >= PH_FRAME && phase_ff < PH_POLL) begin
                  if (bcount_ff < 17'd6) begin
                     bcount_in = bcount_ff + 17'd1;
                     res[0] = sdspi_pkg::f_send(sdspi_pkg::frame_byte(idx,
                              3'(bcount_in), v2_ff, addr_ff));
                  end else begin
                     bcount_in = 17'd1;
                     res[0] = sdspi_pkg::f_send(8'hFF);
                     phase_in = PH_POLL + 6'(idx);
                  end
                  nres = 3'd1;
               end else if (phase_ff >= PH_POLL && phase_ff < PH_T0) begin
                  if (!b[7] || bcount_ff >= {9'd0, poll_lim_ff}) begin
                     r1_in = b;
                     priority case (idx)
                        sdspi_pkg::C_CMD0: begin
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1; phase_in = PH_T0;
                        end
                        sdspi_pkg::C_CMD8: begin
                           bcount_in = '0; flags_in = '0;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1; phase_in = PH_R7;
                        end
                        sdspi_pkg::C_CMD55: begin
                           bcount_in = '0;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                           phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD41);
                        end
                        sdspi_pkg::C_CMD41: begin
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1; phase_in = PH_T41;
                        end
                        sdspi_pkg::C_CMD58: begin
                           bcount_in = '0; flags_in = '0;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1; phase_in = PH_OCR;
                        end
                        sdspi_pkg::C_CMD16: begin
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1; phase_in = PH_T16;
                        end
                        sdspi_pkg::C_CMD17: begin
                           if (b != 8'h00) begin
                              res[0] = sdspi_pkg::f_chip(1'b0);
                              res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_READ_REJ, hc_ff);
                              nres = 3'd2; phase_in = PH_IDLE;
                           end else begin
                              bcount_in = 17'd1;
                              res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                              phase_in = PH_RTOK;
                           end
                        end
                        default: begin
                           if (b != 8'h00) begin
                              res[0] = sdspi_pkg::f_chip(1'b0);
                              res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_WRITE_REJ, hc_ff);
                              nres = 3'd2; phase_in = PH_IDLE;
                           end else begin
                              res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                              phase_in = PH_WGAP;
                           end
                        end
                     endcase
                  end else begin
                     bcount_in = bcount_ff + 17'd1;
                     res[0] = sdspi_pkg::f_send(8'hFF);
                     nres = 3'd1;
                  end
               end else begin
                  priority case (phase_ff)
                     PH_WAKE: begin
                        if (bcount_ff < {9'd0, wake_lim_ff}) begin
                           bcount_in = bcount_ff + 17'd1;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        end else begin
                           bcount_in = '0;
                           res[0] = sdspi_pkg::f_chip(1'b1);
                           res[1] = sdspi_pkg::f_send(8'hFF); nres = 3'd2;
                           phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD0);
                        end
                     end
                     PH_T0: begin
                        res[0] = sdspi_pkg::f_chip(1'b0);
                        if (r1_ff != 8'h01) begin
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_NO_IDLE, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = '0;
                           res[1] = sdspi_pkg::f_chip(1'b1);
                           res[2] = sdspi_pkg::f_send(8'hFF); nres = 3'd3;
                           phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD8);
                        end
                     end
                     PH_R7: begin
                        if (bcount_ff == 17'd2 && b == 8'h01) flags_in[0] = 1'b1;
                        if (bcount_ff == 17'd3 && b == 8'hAA) flags_in[1] = 1'b1;
                        bcount_in = bcount_ff + 17'd1;
                        res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        phase_in = (bcount_in < 17'd4) ? PH_R7 : PH_T8;
                     end
                     PH_T8: begin
                        v2_in = (r1_ff == 8'h01) && (flags_ff == 2'd3);
                        retry_in = '0;
                        bcount_in = '0;
                        res[0] = sdspi_pkg::f_chip(1'b0);
                        res[1] = sdspi_pkg::f_chip(1'b1);
                        res[2] = sdspi_pkg::f_send(8'hFF); nres = 3'd3;
                        phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD55);
                     end
                     PH_T41: begin
                        retry_in = retry_ff + 16'd1;
                        res[0] = sdspi_pkg::f_chip(1'b0);
                        if (r1_ff == 8'h00) begin
                           bcount_in = '0;
                           res[1] = sdspi_pkg::f_chip(1'b1);
                           res[2] = sdspi_pkg::f_send(8'hFF); nres = 3'd3;
                           phase_in = PH_FRAME + (v2_ff ? 6'(sdspi_pkg::C_CMD58)
                                                        : 6'(sdspi_pkg::C_CMD16));
                        end else if (r1_ff[7:1] != 7'd0) begin
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_ACMD41_ERR, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else if (retry_in >= retry_lim_ff) begin
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_ACMD41_TMO, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = '0;
                           res[1] = sdspi_pkg::f_chip(1'b1);
                           res[2] = sdspi_pkg::f_send(8'hFF); nres = 3'd3;
                           phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD55);
                        end
                     end
                     PH_OCR: begin
                        if (bcount_ff == '0 && b[6]) flags_in = 2'd1;
                        bcount_in = bcount_ff + 17'd1;
                        res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        phase_in = (bcount_in < 17'd4) ? PH_OCR : PH_T58;
                     end
                     PH_T58: begin
                        hc_in = (r1_ff == 8'h00) && flags_ff[0];
                        res[0] = sdspi_pkg::f_chip(1'b0);
                        if (hc_in) begin
                           res[1] = sdspi_pkg::f_clock(1'b1);
                           res[2] = sdspi_pkg::f_done(sdspi_pkg::ST_OK, hc_in);
                           nres = 3'd3; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = '0;
                           res[1] = sdspi_pkg::f_chip(1'b1);
                           res[2] = sdspi_pkg::f_send(8'hFF); nres = 3'd3;
                           phase_in = PH_FRAME + 6'(sdspi_pkg::C_CMD16);
                        end
                     end
                     PH_T16: begin
                        res[0] = sdspi_pkg::f_chip(1'b0);
                        if (r1_ff != 8'h00) begin
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_BLKLEN_FAIL, hc_ff);
                           nres = 3'd2;
                        end else begin
                           res[1] = sdspi_pkg::f_clock(1'b1);
                           res[2] = sdspi_pkg::f_done(sdspi_pkg::ST_OK, hc_ff);
                           nres = 3'd3;
                        end
                        phase_in = PH_IDLE;
                     end
                     PH_RTOK: begin
                        if (b == 8'hFE) begin
                           bcount_in = '0;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                           phase_in = PH_RDAT;
                        end else if (bcount_ff >= token_lim_ff) begin
                           res[0] = sdspi_pkg::f_chip(1'b0);
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_TOKEN_TMO, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = bcount_ff + 17'd1;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        end
                     end
                     PH_RDAT: begin
                        res[0] = sdspi_pkg::f_rdata(b);
                        res[1] = sdspi_pkg::f_send(8'hFF); nres = 3'd2;
                        bcount_in = bcount_ff + 17'd1;
                        if (bcount_in >= 17'(sdspi_pkg::BLOCK_BYTES)) begin
                           bcount_in = '0;
                           phase_in = PH_RCRC;
                        end
                     end
                     PH_RCRC: begin
                        bcount_in = bcount_ff + 17'd1;
                        if (bcount_in < 17'd3) begin
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        end else begin
                           res[0] = sdspi_pkg::f_chip(1'b0);
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_OK, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end
                     end
                     PH_WGAP: begin
                        res[0] = sdspi_pkg::f_send(8'hFE); nres = 3'd1;
                        phase_in = PH_WTOK;
                     end
                     PH_WTOK: begin
                        bcount_in = '0;
                        res[0] = sdspi_pkg::f_need(); nres = 3'd1;
                        phase_in = PH_WNEED;
                     end
                     PH_WDAT: begin
                        bcount_in = bcount_ff + 17'd1;
                        if (bcount_in < 17'(sdspi_pkg::BLOCK_BYTES)) begin
                           res[0] = sdspi_pkg::f_need(); nres = 3'd1;
                           phase_in = PH_WNEED;
                        end else begin
                           bcount_in = '0;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                           phase_in = PH_WCRC;
                        end
                     end
                     PH_WCRC: begin
                        bcount_in = bcount_ff + 17'd1;
                        res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        phase_in = (bcount_in < 17'd2) ? PH_WCRC : PH_WRESP;
                     end
                     PH_WRESP: begin
                        if (b[4:0] != 5'h05) begin
                           res[0] = sdspi_pkg::f_chip(1'b0);
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_DATA_REJ, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = 17'd1;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                           phase_in = PH_WBUSY;
                        end
                     end
                     PH_WBUSY: begin
                        if (b != 8'h00) begin
                           res[0] = sdspi_pkg::f_chip(1'b0);
                           res[1] = sdspi_pkg::f_send(8'hFF); nres = 3'd2;
                           phase_in = PH_WTAIL;
                        end else if (bcount_ff >= busy_lim_ff) begin
                           res[0] = sdspi_pkg::f_chip(1'b0);
                           res[1] = sdspi_pkg::f_done(sdspi_pkg::ST_BUSY_TMO, hc_ff);
                           nres = 3'd2; phase_in = PH_IDLE;
                        end else begin
                           bcount_in = bcount_ff + 17'd1;
                           res[0] = sdspi_pkg::f_send(8'hFF); nres = 3'd1;
                        end
                     end
                     PH_WTAIL: begin
                        res[0] = sdspi_pkg::f_done(sdspi_pkg::ST_OK, hc_ff);
                        nres = 3'd1; phase_in = PH_IDLE;
                     end
                     default: begin
                        nres = 3'd0;
                     end
                  endcase
               end
            end
            default: begin
               nres = 3'd0;
            end
         endcase
         if (nres != 3'd0) begin
            res[2'(nres - 3'd1)].is_last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_lim_ff  <= 8'd16;
         retry_lim_ff <= 16'd2000;
         token_lim_ff <= 17'd65536;
         busy_lim_ff  <= 17'd65536;
         wake_lim_ff  <= 8'd16;
      end else if (csr_valid && csr_ready) begin
         priority case (csr_index)
            sdspi_pkg::REG_POLL:  poll_lim_ff  <= csr_data[7:0];
            sdspi_pkg::REG_RETRY: retry_lim_ff <= csr_data[15:0];
            sdspi_pkg::REG_TOKEN: token_lim_ff <= csr_data;
            sdspi_pkg::REG_BUSY:  busy_lim_ff  <= csr_data;
            sdspi_pkg::REG_WAKE:  wake_lim_ff  <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bcount_ff <= '0;
         retry_ff  <= '0;
         addr_ff   <= '0;
         r1_ff     <= 8'hFF;
         v2_ff     <= 1'b0;
         hc_ff     <= 1'b0;
         flags_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         bcount_ff <= bcount_in;
         retry_ff  <= retry_in;
         addr_ff   <= addr_in;
         r1_ff     <= r1_in;
         v2_ff     <= v2_in;
         hc_ff     <= hc_in;
         flags_ff  <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sdspi_pkg::MAX_RESULTS; i++) begin
         if (3'(i) < nres) begin
            queue_ff[PTR_W'(tail_ff + PTR_W'(i))] <= res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (rsp_pop) head_ff <= head_ff + PTR_W'(1);
         tail_ff  <= tail_ff + PTR_W'(nres);
         count_ff <= count_ff + CNT_W'(nres) - CNT_W'(rsp_pop);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(sdspi_pkg::FIFO_DEPTH))
      else $error("result queue overflow");

   a_room_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> count_ff <= CNT_W'(sdspi_pkg::FIFO_DEPTH - sdspi_pkg::MAX_RESULTS))
      else $error("beat taken without queue room");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(phase_ff))
      else $error("phase moved without a request beat");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |-> nres == 3'd0)
      else $error("results pushed without a request beat");

endmodule
`default_nettype wire

// ===== test/sd_spi_mode_host_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
module sd_spi_mode_host_sequencer_core_tb;

   localparam int PH_IDLE  = 0;
   localparam int PH_WAKE  = 1;
   localparam int PH_FRAME = 2;
   localparam int PH_POLL  = 10;
   localparam int PH_T0    = 18;
   localparam int PH_R7    = 19;
   localparam int PH_T8    = 20;
   localparam int PH_T41   = 21;
   localparam int PH_OCR   = 22;
   localparam int PH_T58   = 23;
   localparam int PH_T16   = 24;
   localparam int PH_RTOK  = 25;
   localparam int PH_RDAT  = 26;
   localparam int PH_RCRC  = 27;
   localparam int PH_WGAP  = 28;
   localparam int PH_WTOK  = 29;
   localparam int PH_WNEED = 30;
   localparam int PH_WDAT  = 31;
   localparam int PH_WCRC  = 32;
   localparam int PH_WRESP = 33;
   localparam int PH_WBUSY = 34;
   localparam int PH_WTAIL = 35;

   localparam logic [2:0] OP_BAD_LO = 3'd5;
   localparam logic [2:0] OP_BAD_HI = 3'd7;
   localparam logic [2:0] REG_BAD_LO = 3'd5;
   localparam logic [2:0] REG_BAD_HI = 3'd7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 300;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   sdspi_pkg::req_type  req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   sdspi_pkg::rsp_type  rsp_data;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [16:0]         csr_data;

   sd_spi_mode_host_sequencer_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // card and host model state
   int unsigned m_phase;
   int unsigned m_cnt;
   logic [15:0] m_retry;
   logic [31:0] m_addr;
   logic [7:0]  m_r1;
   logic        m_v2;
   logic        m_hc;
   logic [1:0]  m_flags;
   logic [7:0]  lim_poll;
   logic [15:0] lim_retry;
   logic [16:0] lim_token;
   logic [16:0] lim_busy;
   logic [7:0]  lim_wake;

   sdspi_pkg::rsp_type step_beats[$];
   sdspi_pkg::rsp_type expected_beats[$];

   int mismatch_count = 0;
   int counted_items = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   bit hold_req = 0;
   int long_hold = 0;
   int stall_left = 0;

   // simulated card behavior
   int err_pct, poll_pct, noise_pct;
   bit card_v2, card_ccs, io_reject;
   int acmd_busy_n;

   initial clock = 0;
   always #10 clock = ~clock;

   function automatic logic [7:0] sd_cmd_number(input logic [2:0] idx);
      case (idx)
         sdspi_pkg::C_CMD0:  return 8'd0;
         sdspi_pkg::C_CMD8:  return 8'd8;
         sdspi_pkg::C_CMD55: return 8'd55;
         sdspi_pkg::C_CMD41: return 8'd41;
         sdspi_pkg::C_CMD58: return 8'd58;
         sdspi_pkg::C_CMD16: return 8'd16;
         sdspi_pkg::C_CMD17: return 8'd17;
         default: return 8'd24;
      endcase
   endfunction

   function automatic logic [7:0] sd_cmd_crc(input logic [2:0] idx);
      case (idx)
         sdspi_pkg::C_CMD0:  return 8'h95;
         sdspi_pkg::C_CMD8:  return 8'h87;
         sdspi_pkg::C_CMD55: return 8'h65;
         sdspi_pkg::C_CMD41: return 8'h77;
         sdspi_pkg::C_CMD58: return 8'hFD;
         sdspi_pkg::C_CMD16: return 8'h15;
         default: return 8'hFF;
      endcase
   endfunction

   function automatic logic [31:0] sd_cmd_arg(input logic [2:0] idx);
      case (idx)
         sdspi_pkg::C_CMD8:  return 32'h0000_01AA;
         sdspi_pkg::C_CMD41: return m_v2 ? 32'h4000_0000 : 32'h0;
         sdspi_pkg::C_CMD16: return 32'(sdspi_pkg::BLOCK_BYTES);
         sdspi_pkg::C_CMD17, sdspi_pkg::C_CMD24: return m_addr;
         default: return 32'h0;
      endcase
   endfunction

   function automatic logic [7:0] sd_frame_byte(input logic [2:0] idx, input int unsigned k);
      logic [31:0] a;
      a = sd_cmd_arg(idx);
      if (k == 0) return 8'hFF;
      if (k == 1) return 8'h40 | sd_cmd_number(idx);
      if (k <= 5) return a[8*(5-k) +: 8];
      return sd_cmd_crc(idx);
   endfunction

   function automatic void push_beat(input logic [2:0] kind, input logic [7:0] tx,
                                     input logic cs, input logic fast,
                                     input logic [7:0] data, input logic [3:0] st);
      sdspi_pkg::rsp_type r;
      r = '0;
      r.kind = kind;
      r.tx_byte = tx;
      r.cs_active = cs;
      r.fast_clock = fast;
      r.data_byte = data;
      r.status = st;
      r.high_capacity = (kind == sdspi_pkg::KIND_DONE) && m_hc;
      if (step_beats.size() < sdspi_pkg::MAX_RESULTS) step_beats.push_back(r);
   endfunction

   function automatic void tx_beat(input logic [7:0] b, input int unsigned ph);
      push_beat(sdspi_pkg::KIND_SEND, b, 0, 0, 8'h00, sdspi_pkg::ST_OK);
      m_phase = ph;
   endfunction

   function automatic void cs_beat(input logic lvl);
      push_beat(sdspi_pkg::KIND_CHIP, 8'h00, lvl, 0, 8'h00, sdspi_pkg::ST_OK);
   endfunction

   function automatic void done_beat(input logic [3:0] st);
      push_beat(sdspi_pkg::KIND_DONE, 8'h00, 0, 0, 8'h00, st);
      m_phase = PH_IDLE;
   endfunction

   function automatic void open_cmd(input logic [2:0] idx);
      m_cnt = 0;
      tx_beat(8'hFF, PH_FRAME + idx);
   endfunction

   function automatic void init_ok();
      push_beat(sdspi_pkg::KIND_CLOCK, 8'h00, 0, 1, 8'h00, sdspi_pkg::ST_OK);
      done_beat(sdspi_pkg::ST_OK);
   endfunction

   function automatic void handle_r1(input logic [2:0] idx, input logic [7:0] r);
      case (idx)
         sdspi_pkg::C_CMD0:  tx_beat(8'hFF, PH_T0);
         sdspi_pkg::C_CMD8:  begin m_cnt = 0; m_flags = 0; tx_beat(8'hFF, PH_R7); end
         sdspi_pkg::C_CMD55: open_cmd(sdspi_pkg::C_CMD41);
         sdspi_pkg::C_CMD41: tx_beat(8'hFF, PH_T41);
         sdspi_pkg::C_CMD58: begin m_cnt = 0; m_flags = 0; tx_beat(8'hFF, PH_OCR); end
         sdspi_pkg::C_CMD16: tx_beat(8'hFF, PH_T16);
         sdspi_pkg::C_CMD17: begin
            if (r != 0) begin cs_beat(0); done_beat(sdspi_pkg::ST_READ_REJ); end
            else begin m_cnt = 1; tx_beat(8'hFF, PH_RTOK); end
         end
         default: begin
            if (r != 0) begin cs_beat(0); done_beat(sdspi_pkg::ST_WRITE_REJ); end
            else tx_beat(8'hFF, PH_WGAP);
         end
      endcase
   endfunction

   function automatic void card_reply(input logic [7:0] b);
      logic [2:0] idx;
      if (m_phase >= PH_FRAME && m_phase < PH_POLL) begin
         idx = 3'(m_phase - PH_FRAME);
         if (m_cnt < 6) begin
            m_cnt++;
            tx_beat(sd_frame_byte(idx, m_cnt), m_phase);
         end else begin
            m_cnt = 1;
            tx_beat(8'hFF, PH_POLL + idx);
         end
         return;
      end
      if (m_phase >= PH_POLL && m_phase < PH_T0) begin
         idx = 3'(m_phase - PH_POLL);
         if (!b[7] || m_cnt >= lim_poll) begin
            m_r1 = b;
            handle_r1(idx, b);
         end else begin
            m_cnt++;
            tx_beat(8'hFF, m_phase);
         end
         return;
      end
      case (m_phase)
         PH_WAKE: begin
            if (m_cnt < lim_wake) begin m_cnt++; tx_beat(8'hFF, PH_WAKE); end
            else begin cs_beat(1); open_cmd(sdspi_pkg::C_CMD0); end
         end
         PH_T0: begin
            cs_beat(0);
            if (m_r1 != 8'h01) done_beat(sdspi_pkg::ST_NO_IDLE);
            else begin cs_beat(1); open_cmd(sdspi_pkg::C_CMD8); end
         end
         PH_R7: begin
            if (m_cnt == 2 && b == 8'h01) m_flags[0] = 1;
            if (m_cnt == 3 && b == 8'hAA) m_flags[1] = 1;
            m_cnt++;
            tx_beat(8'hFF, m_cnt < 4 ? PH_R7 : PH_T8);
         end
         PH_T8: begin
            cs_beat(0);
            m_v2 = (m_r1 == 8'h01) && (m_flags == 2'd3);
            m_retry = 0;
            cs_beat(1);
            open_cmd(sdspi_pkg::C_CMD55);
         end
         PH_T41: begin
            cs_beat(0);
            m_retry = m_retry + 16'd1;
            if (m_r1 == 8'h00) begin
               cs_beat(1);
               open_cmd(m_v2 ? sdspi_pkg::C_CMD58 : sdspi_pkg::C_CMD16);
            end else if ((m_r1 & 8'hFE) != 0) done_beat(sdspi_pkg::ST_ACMD41_ERR);
            else if (m_retry >= lim_retry) done_beat(sdspi_pkg::ST_ACMD41_TMO);
            else begin cs_beat(1); open_cmd(sdspi_pkg::C_CMD55); end
         end
         PH_OCR: begin
            if (m_cnt == 0 && b[6]) m_flags = 2'd1;
            m_cnt++;
            tx_beat(8'hFF, m_cnt < 4 ? PH_OCR : PH_T58);
         end
         PH_T58: begin
            cs_beat(0);
            m_hc = (m_r1 == 8'h00) && m_flags[0];
            if (m_hc) init_ok();
            else begin cs_beat(1); open_cmd(sdspi_pkg::C_CMD16); end
         end
         PH_T16: begin
            cs_beat(0);
            if (m_r1 != 8'h00) done_beat(sdspi_pkg::ST_BLKLEN_FAIL);
            else init_ok();
         end
         PH_RTOK: begin
            if (b == 8'hFE) begin m_cnt = 0; tx_beat(8'hFF, PH_RDAT); end
            else if (m_cnt >= lim_token) begin
               cs_beat(0); done_beat(sdspi_pkg::ST_TOKEN_TMO);
            end
            else begin m_cnt++; tx_beat(8'hFF, PH_RTOK); end
         end
         PH_RDAT: begin
            push_beat(sdspi_pkg::KIND_RDATA, 8'h00, 0, 0, b, sdspi_pkg::ST_OK);
            m_cnt++;
            if (m_cnt < sdspi_pkg::BLOCK_BYTES) tx_beat(8'hFF, PH_RDAT);
            else begin m_cnt = 0; tx_beat(8'hFF, PH_RCRC); end
         end
         PH_RCRC: begin
            m_cnt++;
            if (m_cnt < 3) tx_beat(8'hFF, PH_RCRC);
            else begin cs_beat(0); done_beat(sdspi_pkg::ST_OK); end
         end
         PH_WGAP: tx_beat(8'hFE, PH_WTOK);
         PH_WTOK: begin
            m_cnt = 0;
            push_beat(sdspi_pkg::KIND_NEED, 8'h00, 0, 0, 8'h00, sdspi_pkg::ST_OK);
            m_phase = PH_WNEED;
         end
         PH_WDAT: begin
            m_cnt++;
            if (m_cnt < sdspi_pkg::BLOCK_BYTES) begin
               push_beat(sdspi_pkg::KIND_NEED, 8'h00, 0, 0, 8'h00, sdspi_pkg::ST_OK);
               m_phase = PH_WNEED;
            end else begin m_cnt = 0; tx_beat(8'hFF, PH_WCRC); end
         end
         PH_WCRC: begin
            m_cnt++;
            tx_beat(8'hFF, m_cnt < 2 ? PH_WCRC : PH_WRESP);
         end
         PH_WRESP: begin
            if ((b & 8'h1F) != 8'h05) begin cs_beat(0); done_beat(sdspi_pkg::ST_DATA_REJ); end
            else begin m_cnt = 1; tx_beat(8'hFF, PH_WBUSY); end
         end
         PH_WBUSY: begin
            if (b != 0) begin cs_beat(0); tx_beat(8'hFF, PH_WTAIL); end
            else if (m_cnt >= lim_busy) begin cs_beat(0); done_beat(sdspi_pkg::ST_BUSY_TMO); end
            else begin m_cnt++; tx_beat(8'hFF, PH_WBUSY); end
         end
         PH_WTAIL: done_beat(sdspi_pkg::ST_OK);
         default: ;
      endcase
   endfunction

   function automatic void predict_sequencer_beats(input sdspi_pkg::req_type rq);
      step_beats.delete();
      case (rq.op)
         sdspi_pkg::OP_INIT: if (m_phase == PH_IDLE) begin
            m_v2 = 0;
            m_hc = 0;
            push_beat(sdspi_pkg::KIND_CLOCK, 8'h00, 0, 0, 8'h00, sdspi_pkg::ST_OK);
            cs_beat(0);
            m_cnt = 1;
            tx_beat(8'hFF, PH_WAKE);
         end
         sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: if (m_phase == PH_IDLE) begin
            m_addr = m_hc ? rq.lba : (rq.lba << sdspi_pkg::BLK_SHIFT);
            cs_beat(1);
            open_cmd(rq.op == sdspi_pkg::OP_READ ? sdspi_pkg::C_CMD17 : sdspi_pkg::C_CMD24);
         end
         sdspi_pkg::OP_REPLY:
            if (m_phase != PH_IDLE && m_phase != PH_WNEED) card_reply(rq.byte_in);
         sdspi_pkg::OP_WDATA: if (m_phase == PH_WNEED) tx_beat(rq.byte_in, PH_WDAT);
         default: ;
      endcase
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].is_last = 1;
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
   endfunction

   function automatic logic [7:0] pick_card_byte();
      logic [7:0] r;
      logic [2:0] idx;
      r = 8'($urandom);
      if (m_phase >= PH_POLL && m_phase < PH_T0) begin
         idx = 3'(m_phase - PH_POLL);
         if ($urandom_range(99) < poll_pct) return r | 8'h80;
         if ($urandom_range(99) < err_pct) return (r == 8'h01) ? 8'h03 : r;
         case (idx)
            sdspi_pkg::C_CMD0, sdspi_pkg::C_CMD55: return 8'h01;
            sdspi_pkg::C_CMD8:  return card_v2 ? 8'h01 : 8'h05;
            sdspi_pkg::C_CMD41: return (m_retry < acmd_busy_n) ? 8'h01 : 8'h00;
            sdspi_pkg::C_CMD17, sdspi_pkg::C_CMD24: return io_reject ? 8'h04 : 8'h00;
            default: return 8'h00;
         endcase
      end
      case (m_phase)
         PH_R7: begin
            if (card_v2 && m_cnt == 2) return 8'h01;
            if (card_v2 && m_cnt == 3) return 8'hAA;
         end
         PH_OCR: if (m_cnt == 0) return card_ccs ? (r | 8'h40) : (r & 8'hBF);
         PH_RTOK: return (r == 8'hFE) ? 8'hFF : r;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [31:0] lba,
                            input logic [7:0] b);
      sdspi_pkg::req_type rq;
      rq.op = op;
      rq.lba = lba;
      rq.byte_in = b;
      @(negedge clock);
      if (!quiet && $urandom_range(5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_sequencer_beats(rq);
      counted_items++;
   endtask

   task automatic inject_noise();
      int n;
      n = $urandom_range(2);
      if (n == 0) send_item(3'($urandom_range(2)), $urandom, 8'($urandom));
      else if (n == 1) send_item(3'($urandom_range(OP_BAD_LO, OP_BAD_HI)), $urandom,
                                 8'($urandom));
      else if (m_phase == PH_WNEED) send_item(sdspi_pkg::OP_REPLY, $urandom, 8'($urandom));
      else send_item(sdspi_pkg::OP_WDATA, $urandom, 8'($urandom));
   endtask

   task automatic run_sequence(input logic [2:0] op, input logic [31:0] lba);
      send_item(op, lba, 8'($urandom));
      while (m_phase != PH_IDLE) begin
         if ($urandom_range(99) < noise_pct) inject_noise();
         if (m_phase == PH_WNEED) send_item(sdspi_pkg::OP_WDATA, $urandom, 8'($urandom));
         else send_item(sdspi_pkg::OP_REPLY, $urandom, pick_card_byte());
      end
   endtask

   task automatic set_card(input int e, input int p, input bit v2, input bit ccs,
                           input int busy_n, input bit rej);
      err_pct = e;
      poll_pct = p;
      card_v2 = v2;
      card_ccs = ccs;
      acmd_busy_n = busy_n;
      io_reject = rej;
      noise_pct = 5;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_beats.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sdspi_pkg::REG_POLL:  lim_poll = value[7:0];
         sdspi_pkg::REG_RETRY: lim_retry = value[15:0];
         sdspi_pkg::REG_TOKEN: lim_token = value;
         sdspi_pkg::REG_BUSY:  lim_busy = value;
         sdspi_pkg::REG_WAKE:  lim_wake = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int poll, input int retry, input int token,
                            input int busy, input int wake);
      settle();
      csr_write(sdspi_pkg::REG_POLL, 17'(poll));
      csr_write(sdspi_pkg::REG_RETRY, 17'(retry));
      csr_write(sdspi_pkg::REG_TOKEN, 17'(token));
      csr_write(sdspi_pkg::REG_BUSY, 17'(busy));
      csr_write(sdspi_pkg::REG_WAKE, 17'(wake));
   endtask

   task automatic test_idle_noise();
      send_item(sdspi_pkg::OP_REPLY, 32'hFFFF_FFFF, 8'hFF);
      send_item(sdspi_pkg::OP_WDATA, 32'h0, 8'h00);
      for (int op = OP_BAD_LO; op <= OP_BAD_HI; op++) send_item(3'(op), $urandom, 8'hA5);
   endtask

   task automatic test_config_port();
      configure(4, 2, 3, 2, 10);
      csr_write(REG_BAD_LO, 17'h1FFFF);
      csr_write(REG_BAD_HI, 17'h0);
   endtask

   task automatic test_io_before_init();
      set_card(0, 0, 1, 1, 0, 1);
      run_sequence(sdspi_pkg::OP_READ, 32'hFFFF_FFFF);
      run_sequence(sdspi_pkg::OP_WRITE, 32'h8000_0001);
      set_card(0, 0, 1, 1, 0, 0);
      run_sequence(sdspi_pkg::OP_READ, $urandom);
   endtask

   task automatic test_no_idle();
      set_card(100, 0, 1, 1, 0, 0);
      run_sequence(sdspi_pkg::OP_INIT, $urandom);
   endtask

   task automatic test_init_high_capacity();
      set_card(0, 20, 1, 1, 0, 0);
      run_sequence(sdspi_pkg::OP_INIT, $urandom);
      run_sequence(sdspi_pkg::OP_READ, $urandom);
   endtask

   task automatic test_init_standard();
      set_card(0, 0, 0, 0, 1, 0);
      run_sequence(sdspi_pkg::OP_INIT, $urandom);
   endtask

   task automatic test_backpressure();
      settle();
      set_card(0, 0, 1, 1, 0, 1);
      hold_req = 1;
      run_sequence(sdspi_pkg::OP_READ, $urandom);
      run_sequence(sdspi_pkg::OP_WRITE, $urandom);
      set_card(0, 0, 1, 1, 0, 0);
      run_sequence(sdspi_pkg::OP_READ, $urandom);
      settle();
   endtask

   task automatic test_quiet_tail();
      quiet = 1;
      set_card(0, 20, 1, 1, 0, 0);
      run_sequence(sdspi_pkg::OP_READ, $urandom);
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 0;
         long_hold = LONG_HOLD;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && !reset && $urandom_range(7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      sdspi_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected beat: %p", rsp_data);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("beat mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      m_phase = PH_IDLE;
      m_cnt = 0;
      m_retry = 0;
      m_addr = 0;
      m_r1 = 8'hFF;
      m_v2 = 0;
      m_hc = 0;
      m_flags = 0;
      lim_poll = 8'd16;
      lim_retry = 16'd2000;
      lim_token = 17'd65536;
      lim_busy = 17'd65536;
      lim_wake = 8'd16;
      set_card(0, 0, 1, 1, 0, 0);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_noise();
      test_config_port();
      test_io_before_init();
      test_no_idle();
      test_init_high_capacity();
      test_init_standard();
      test_backpressure();
      test_quiet_tail();
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
sv/sdspi_pkg.sv
sv/sd_spi_mode_host_sequencer_core.sv
test/sd_spi_mode_host_sequencer_core_tb.sv
